FILE: sv/ale_pkg.sv
package ale_pkg;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_GET    = 3'd1,
    OP_SET    = 3'd2,
    OP_INSERT = 3'd3,
    OP_APPEND = 3'd4,
    OP_DELETE = 3'd5,
    OP_SEARCH = 3'd6
  } ale_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_CLEAR,
    S_GETW,
    S_SHIFT,
    S_PLACE,
    S_SEARCH,
    S_FINISH
  } ale_state_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [31:0] ERR_VALUE = 32'hFFFF_FFFF;

endpackage

FILE: sv/ale_mem.sv
module ale_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/array_list_engine_core.sv
// Bounded ordered list of 32-bit words kept in a single-port-write, single-port-read
// memory of CAPACITY entries. One request word in, one result word out. The block
// handles one request at a time and walks the memory one entry per cycle through a
// pipelined read/write index counter, so the cost is set by the list walk: create
// clears the new length's entries, insert or append moves the entries from position
// up one slot, delete moves the entries above position down one slot, and search
// reads until the word is hit or the list ends; set, get, errors and unused codes
// do not walk the list. Loading of the output register waits while an unread result
// holds that register. A finished result sits in the output register, so the next
// request is taken while the result still waits to be read. Entries beyond the
// current length are never read, so the memory needs no clearing after reset.
module array_list_engine_core #(
  parameter int CAPACITY = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_operation,
  input  logic [8:0]         in_position,
  input  logic signed [31:0] in_value,
  input  logic [8:0]         in_length_arg,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_read_value,
  output logic               out_found,
  output logic [7:0]         out_found_position,
  output logic [8:0]         out_list_length
);

  import ale_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int LW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (LW > 9) ? LW : 9;
  localparam logic [CMPW-1:0] CAP_C = CMPW'(CAPACITY);

  ale_state_t state_r, state_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  logic [LW-1:0]   idx_r, idx_nxt;
  logic            wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]   wr_addr_r, wr_addr_nxt;
  logic            cmp_pend_r, cmp_pend_nxt;
  logic [AW-1:0]   cmp_idx_r, cmp_idx_nxt;

  ale_op_t         op_r, op_nxt;
  logic [CMPW-1:0] pos_r, pos_nxt;
  logic [31:0]     val_r, val_nxt;
  logic [CMPW-1:0] larg_r, larg_nxt;

  logic [1:0]      res_status_r, res_status_nxt;
  logic [31:0]     res_value_r, res_value_nxt;
  logic            res_found_r, res_found_nxt;
  logic [AW-1:0]   res_fpos_r, res_fpos_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_status_r, out_status_nxt;
  logic [31:0]     out_value_r, out_value_nxt;
  logic            out_found_r, out_found_nxt;
  logic [7:0]      out_fpos_r, out_fpos_nxt;
  logic [8:0]      out_len_r, out_len_nxt;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [31:0]     mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [31:0]     mem_rdata;

  logic [CMPW-1:0] len_c;
  logic [CMPW-1:0] idx_c;
  logic [CMPW-1:0] ins_pos;
  logic [LW-1:0]   idx_inc;
  logic [LW-1:0]   idx_dec;
  logic            hit;

  ale_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (32)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign len_c   = CMPW'(len_r);
  assign idx_c   = CMPW'(idx_r);
  assign idx_inc = idx_r + LW'(1);
  assign idx_dec = idx_r - LW'(1);
  assign ins_pos = (op_r == OP_APPEND) ? len_c : pos_r;
  assign hit     = cmp_pend_r && (mem_rdata == val_r);

  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    idx_nxt        = idx_r;
    wr_pend_nxt    = 1'b0;
    wr_addr_nxt    = wr_addr_r;
    cmp_pend_nxt   = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    larg_nxt       = larg_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    res_found_nxt  = res_found_r;
    res_fpos_nxt   = res_fpos_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_found_nxt  = out_found_r;
    out_fpos_nxt   = out_fpos_r;
    out_len_nxt    = out_len_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    // shift move: the word read last cycle lands one slot over
    if (wr_pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr_r;
      mem_wdata = mem_rdata;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = ale_op_t'(in_operation);
          pos_nxt   = CMPW'(in_position);
          val_nxt   = in_value;
          larg_nxt  = CMPW'(in_length_arg);
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        res_status_nxt = ST_OK;
        res_value_nxt  = '0;
        res_found_nxt  = 1'b0;
        res_fpos_nxt   = '0;
        state_nxt      = S_FINISH;
        unique case (op_r) inside
          OP_CREATE: begin
            if (larg_r > CAP_C) begin
              res_status_nxt = ST_RANGE;
              res_value_nxt  = ERR_VALUE;
            end else begin
              len_nxt = LW'(larg_r);
              idx_nxt = '0;
              if (larg_r != '0) begin
                state_nxt = S_CLEAR;
              end
            end
          end
          OP_GET, OP_SET: begin
            if (pos_r < len_c) begin
              if (op_r == OP_SET) begin
                mem_we        = 1'b1;
                mem_waddr     = AW'(pos_r);
                mem_wdata     = val_r;
                res_value_nxt = val_r;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = AW'(pos_r);
                state_nxt = S_GETW;
              end
            end else begin
              res_status_nxt = ST_RANGE;
              res_value_nxt  = ERR_VALUE;
            end
          end
          OP_INSERT, OP_APPEND: begin
            if (ins_pos > len_c) begin
              res_status_nxt = ST_RANGE;
              res_value_nxt  = ERR_VALUE;
            end else if (len_c >= CAP_C) begin
              res_status_nxt = ST_FULL;
              res_value_nxt  = ERR_VALUE;
            end else begin
              pos_nxt   = ins_pos;
              idx_nxt   = len_r;
              state_nxt = S_SHIFT;
            end
          end
          OP_DELETE: begin
            if (pos_r < len_c) begin
              idx_nxt   = LW'(pos_r);
              state_nxt = S_SHIFT;
            end else begin
              res_status_nxt = ST_RANGE;
              res_value_nxt  = ERR_VALUE;
            end
          end
          OP_SEARCH: begin
            idx_nxt   = '0;
            state_nxt = S_SEARCH;
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end

      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(idx_r);
        mem_wdata = '0;
        idx_nxt   = idx_inc;
        if (idx_inc == len_r) begin
          state_nxt = S_FINISH;
        end
      end

      S_GETW: begin
        res_value_nxt = mem_rdata;
        state_nxt     = S_FINISH;
      end

      S_SHIFT: begin
        if (op_r == OP_DELETE) begin
          if ((idx_c + CMPW'(1)) >= len_c) begin
            len_nxt   = len_r - LW'(1);
            state_nxt = S_FINISH;
          end else begin
            mem_re      = 1'b1;
            mem_raddr   = AW'(idx_inc);
            wr_pend_nxt = 1'b1;
            wr_addr_nxt = AW'(idx_r);
            idx_nxt     = idx_inc;
          end
        end else begin
          if (idx_c == pos_r) begin
            state_nxt = S_PLACE;
          end else begin
            mem_re      = 1'b1;
            mem_raddr   = AW'(idx_dec);
            wr_pend_nxt = 1'b1;
            wr_addr_nxt = AW'(idx_r);
            idx_nxt     = idx_dec;
          end
        end
      end

      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(pos_r);
        mem_wdata = val_r;
        len_nxt   = len_r + LW'(1);
        state_nxt = S_FINISH;
      end

      S_SEARCH: begin
        // compare of the word read last cycle overlaps the next read
        if (hit) begin
          res_found_nxt = 1'b1;
          res_fpos_nxt  = cmp_idx_r;
          state_nxt     = S_FINISH;
        end else if (idx_c < len_c) begin
          mem_re       = 1'b1;
          mem_raddr    = AW'(idx_r);
          cmp_pend_nxt = 1'b1;
          cmp_idx_nxt  = AW'(idx_r);
          idx_nxt      = idx_inc;
        end else if (!cmp_pend_r) begin
          state_nxt = S_FINISH;
        end
      end

      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_found_nxt  = res_found_r;
          out_fpos_nxt   = 8'(res_fpos_r);
          out_len_nxt    = 9'(len_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      wr_pend_r   <= 1'b0;
      cmp_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      wr_pend_r   <= wr_pend_nxt;
      cmp_pend_r  <= cmp_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    wr_addr_r    <= wr_addr_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    larg_r       <= larg_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_found_r  <= res_found_nxt;
    res_fpos_r   <= res_fpos_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_found_r  <= out_found_nxt;
    out_fpos_r   <= out_fpos_nxt;
    out_len_r    <= out_len_nxt;
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_read_value     = out_value_r;
  assign out_found          = out_found_r;
  assign out_found_position = out_fpos_r;
  assign out_list_length    = out_len_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(len_r) <= CAP_C)
    else $error("list length above capacity");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result word raised outside finish");

  a_move_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> (state_r == S_SHIFT) && $past(state_r == S_SHIFT))
    else $error("pending shift write outside shift walk");

  a_cmp_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_pend_r |-> (state_r == S_SEARCH) && !mem_we)
    else $error("pending compare outside search walk");

endmodule
